// ===== rtl/modexp_pkg.sv =====
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types, constants and the microcode program of the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Fixed stream field widths
  localparam int BASE_W        = 63;
  localparam int EXP_IN_W      = 63;
  localparam int MOD_IN_W      = 32;
  localparam int RESULT_W      = 32;
  localparam int IN_TDATA_W    = 128;
  localparam logic [MOD_IN_W-1:0] RESET_MODULUS = 32'd1000000007;

  // Microcode addressing
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t ST_IDLE     = 4'd0;
  localparam upc_t ST_RED_BASE = 4'd1;
  localparam upc_t ST_LOOP     = 4'd3;
  localparam upc_t ST_RED_MUL  = 4'd6;
  localparam upc_t ST_SHIFT    = 4'd8;
  localparam upc_t ST_RED_SQR  = 4'd11;
  localparam upc_t ST_WAIT_OUT = 4'd13;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_LOAD    = 4'd1,   // take request, base into reducer
    OP_RED     = 4'd2,   // one restoring reduction step
    OP_WR_B    = 4'd3,   // base <= remainder
    OP_MUL_AB  = 4'd4,   // reducer <= acc * base
    OP_WR_ACC  = 4'd5,   // acc <= remainder
    OP_SHIFT_E = 4'd6,   // exponent >>= 1
    OP_MUL_BB  = 4'd7,   // reducer <= base * base
    OP_OUT     = 4'd8    // load output register
  } op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_START  = 3'd2,
    C_RED_MORE  = 3'd3,
    C_E_ZERO    = 3'd4,
    C_LSB_CLEAR = 3'd5,
    C_OUT_FULL  = 3'd6
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic red_more;
    logic e_zero;
    logic e_lsb;
    logic out_full;
  } status_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t  op;
    logic idle;
  } ctrl_t;

  // Microcode program: jump to target when cond holds, else fall through
  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
    case (addr)
      4'd0:  w = '{op: OP_LOAD,    cond: C_NO_START,  target: ST_IDLE};
      4'd1:  w = '{op: OP_RED,     cond: C_RED_MORE,  target: ST_RED_BASE};
      4'd2:  w = '{op: OP_WR_B,    cond: C_NEVER,     target: ST_IDLE};
      4'd3:  w = '{op: OP_NOP,     cond: C_E_ZERO,    target: ST_WAIT_OUT};
      4'd4:  w = '{op: OP_NOP,     cond: C_LSB_CLEAR, target: ST_SHIFT};
      4'd5:  w = '{op: OP_MUL_AB,  cond: C_NEVER,     target: ST_IDLE};
      4'd6:  w = '{op: OP_RED,     cond: C_RED_MORE,  target: ST_RED_MUL};
      4'd7:  w = '{op: OP_WR_ACC,  cond: C_NEVER,     target: ST_IDLE};
      4'd8:  w = '{op: OP_SHIFT_E, cond: C_NEVER,     target: ST_IDLE};
      4'd9:  w = '{op: OP_NOP,     cond: C_E_ZERO,    target: ST_WAIT_OUT};
      4'd10: w = '{op: OP_MUL_BB,  cond: C_NEVER,     target: ST_IDLE};
      4'd11: w = '{op: OP_RED,     cond: C_RED_MORE,  target: ST_RED_SQR};
      4'd12: w = '{op: OP_WR_B,    cond: C_ALWAYS,    target: ST_LOOP};
      4'd13: w = '{op: OP_NOP,     cond: C_OUT_FULL,  target: ST_WAIT_OUT};
      4'd14: w = '{op: OP_OUT,     cond: C_ALWAYS,    target: ST_IDLE};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS,    target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/modexp_seq.sv =====
// ----------------------------------------------------------------------------
// modexp_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module modexp_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  modexp_pkg::status_t status,
  output modexp_pkg::ctrl_t   ctrl
);

  modexp_pkg::upc_t   upc_r;
  modexp_pkg::upc_t   upc_nxt;
  modexp_pkg::uword_t uword;
  logic               take_jump;

  // Fetch current control word
  assign uword = modexp_pkg::ucode_rom(upc_r);

  // Jump condition select
  always_comb begin
    case (uword.cond)
      modexp_pkg::C_NEVER:     take_jump = 1'b0;
      modexp_pkg::C_ALWAYS:    take_jump = 1'b1;
      modexp_pkg::C_NO_START:  take_jump = !status.start;
      modexp_pkg::C_RED_MORE:  take_jump = status.red_more;
      modexp_pkg::C_E_ZERO:    take_jump = status.e_zero;
      modexp_pkg::C_LSB_CLEAR: take_jump = !status.e_lsb;
      modexp_pkg::C_OUT_FULL:  take_jump = status.out_full;
      default:                 take_jump = 1'b1;
    endcase
  end

  assign upc_nxt = take_jump ? uword.target : upc_r + modexp_pkg::upc_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= modexp_pkg::ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctrl.op   = uword.op;
  assign ctrl.idle = (upc_r == modexp_pkg::ST_IDLE);

endmodule

// ===== rtl/modular_exponentiation.sv =====
// The base is reduced first over DW = max(63, 2*MOD_WIDTH) bits. Then each exponent
// bit below the top set bit runs a multiply and reduce when set, then a square and
// reduce; the top set bit only a multiply and reduce. The result is then delivered.
// One request at a time; the one-bit-per-cycle remainder loop sets the rate.
// A new request is taken while the previous result waits in the output register.
// Reset (rst_n, synchronous) idles the sequencer, empties the output, modulus = 1e9+7.
// ----------------------------------------------------------------------------
// modular_exponentiation
// base^exponent mod modulus by right-to-left square-and-multiply on a
// microcoded datapath with one shared restoring remainder unit.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 63
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [62:0] base_value, [125:63] exponent, [127:126] zero
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [modexp_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata: [31:0] power_result
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [modexp_pkg::RESULT_W-1:0]      out_tdata,
  // out_tuser: [0] fault
  output logic                                 out_tuser,
  input  logic                                 cfg_wr_en,
  input  logic [modexp_pkg::MOD_IN_W-1:0]      cfg_wr_data
);

  localparam int DW    = (2 * MOD_WIDTH > modexp_pkg::BASE_W) ? 2 * MOD_WIDTH
                                                              : modexp_pkg::BASE_W;
  localparam int CNT_W = $clog2(DW + 1);

  modexp_pkg::status_t status;
  modexp_pkg::ctrl_t   ctrl;

  logic [MOD_WIDTH-1:0]   mod_r;
  logic [MOD_WIDTH-1:0]   b_r;
  logic [MOD_WIDTH-1:0]   acc_r;
  logic [EXP_WIDTH-1:0]   e_r;
  logic [DW-1:0]          div_r;
  logic [MOD_WIDTH-1:0]   rem_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   out_valid_r;
  logic [MOD_WIDTH-1:0]   out_data_r;
  logic                   out_fault_r;

  logic [MOD_WIDTH:0]     shifted;
  logic [MOD_WIDTH+1:0]   diff;
  logic [MOD_WIDTH-1:0]   rem_nxt;
  logic [2*MOD_WIDTH-1:0] mul_a;
  logic [2*MOD_WIDTH-1:0] mul_b;
  logic                   in_fire;
  logic                   out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;

  // Sequencer
  assign status.start    = in_tvalid;
  assign status.red_more = (cnt_r > CNT_W'(1));
  assign status.e_zero   = (e_r == '0);
  assign status.e_lsb    = e_r[0];
  assign status.out_full = out_valid_r;

  modexp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_tready = ctrl.idle;

  // Modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MOD_WIDTH'(modexp_pkg::RESET_MODULUS);
    end else if (cfg_wr_en) begin
      mod_r <= MOD_WIDTH'(cfg_wr_data);
    end
  end

  // Restoring remainder step: shift in next dividend bit, subtract if it fits
  assign shifted = {rem_r, div_r[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, mod_r};
  assign rem_nxt = diff[MOD_WIDTH+1] ? shifted[MOD_WIDTH-1:0] : diff[MOD_WIDTH-1:0];

  // Shared multiplier operands
  assign mul_a = {{MOD_WIDTH{1'b0}}, (ctrl.op == modexp_pkg::OP_MUL_AB) ? acc_r : b_r};
  assign mul_b = {{MOD_WIDTH{1'b0}}, b_r};

  // Datapath
  always_ff @(posedge clk) begin
    case (ctrl.op)
      modexp_pkg::OP_LOAD: begin
        if (in_fire) begin
          div_r <= DW'(in_tdata[modexp_pkg::BASE_W-1:0]);
          e_r   <= EXP_WIDTH'(in_tdata[modexp_pkg::BASE_W +: modexp_pkg::EXP_IN_W]);
          acc_r <= MOD_WIDTH'(1);
          rem_r <= '0;
          cnt_r <= CNT_W'(DW);
        end
      end
      modexp_pkg::OP_RED: begin
        rem_r <= rem_nxt;
        div_r <= div_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      modexp_pkg::OP_WR_B: begin
        b_r <= rem_r;
      end
      modexp_pkg::OP_MUL_AB, modexp_pkg::OP_MUL_BB: begin
        div_r <= DW'(mul_a * mul_b);
        rem_r <= '0;
        cnt_r <= CNT_W'(DW);
      end
      modexp_pkg::OP_WR_ACC: begin
        acc_r <= rem_r;
      end
      modexp_pkg::OP_SHIFT_E: begin
        e_r <= e_r >> 1;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == modexp_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == modexp_pkg::OP_OUT) begin
      out_fault_r <= (mod_r == '0);
      out_data_r  <= (mod_r == '0) ? '0 : acc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = modexp_pkg::RESULT_W'(out_data_r);
  assign out_tuser  = out_fault_r;

`ifndef SYNTH
  // Busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("ready still high after request");

  // Fault flag tracks a zero modulus
  a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fault_r == (mod_r == '0)))
    else $error("fault flag does not match modulus");

  // Faulted result is forced to zero
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (out_data_r == '0))
    else $error("nonzero result with fault");

  // Result is fully reduced for a modulus above one
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (mod_r > MOD_WIDTH'(1))) |-> (out_data_r < mod_r))
    else $error("result not below modulus");

  // Remainder stays reduced while the unit runs
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == modexp_pkg::OP_RED && mod_r != '0) |=> (rem_r < mod_r))
    else $error("remainder out of range");
`endif

endmodule
